// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== rtl/sfa_pkg.sv =====
// Types, codes and helper functions of the segregated free list allocator.
// No dependencies.
`default_nettype none
package sfa_pkg;
	localparam int ADDR_W      = 17;
	localparam int SIZE_W      = 22;
	localparam int WORD_W      = 23;
	localparam int CLS_W       = 5;
	localparam int MAX_CLASSES = 24;
	localparam int SZ_W        = 28;
	localparam int ADDR_SPAN   = 131072;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO      = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef struct packed {
		req_type_t           req_type;
		logic [SIZE_W-1:0]   req_size;
		logic [ADDR_W-1:0]   block_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   result_addr;
		status_t             status;
	} rsp_t;

	typedef struct packed {
		logic                is_free;
		logic [ADDR_W-1:0]   addr;
		logic [CLS_W-1:0]    cls;
		status_t             status;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_FREE_HDR,
		S_FREE_LINK,
		S_POP_HDR,
		S_POP_LINK,
		S_CARVE_A,
		S_CARVE_B,
		S_RESP
	} state_t;

	// smallest class whose block size (8 << i) holds size, capped at the last class
	function automatic logic [CLS_W-1:0] class_of(input logic [SZ_W-1:0] size,
			input int num_classes);
		logic [CLS_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_CLASSES - 1; i++) begin
			if (i < num_classes - 1 && size > (SZ_W'(8) << i))
				c = CLS_W'(i + 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/sfa_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sfa_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/sfa_front.sv =====
// Front end: accepts request words, sizes and classifies them, queues commands.
// Depends on sfa_pkg.
`default_nettype none
module sfa_front #(
	parameter int NUM_CLASSES = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sfa_pkg::req_t req,
	output logic               cmd_valid,
	input  wire logic          cmd_pop,
	output sfa_pkg::cmd_t      cmd
);
	import sfa_pkg::*;

	cmd_t            q_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic [WORD_W-1:0] sum, asize;
	cmd_t            c_new;

	always_comb begin
		sum   = {1'b0, req.req_size} + WORD_W'(8);
		asize = (sum < WORD_W'(16)) ? WORD_W'(16) : sum;
		c_new.is_free = (req.req_type == REQ_FREE);
		c_new.addr    = req.block_addr;
		c_new.cls     = class_of(SZ_W'(asize), NUM_CLASSES);
		if (req.req_type == REQ_FREE)
			c_new.status = ST_OK;
		else if (req.req_size == '0)
			c_new.status = ST_ZERO;
		else if (SZ_W'(asize) > (SZ_W'(8) << (NUM_CLASSES - 1)))
			c_new.status = ST_TOO_LARGE;
		else
			c_new.status = ST_OK;
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			q_q[wp_q] <= c_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (cmd_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/sfa_back.sv =====
// Back end: executes queued commands against the class heads, break and heap RAM.
// Depends on sfa_pkg and sfa_ram.
`default_nettype none
module sfa_back #(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096,
	parameter int NUM_CLASSES = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	input  wire sfa_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sfa_pkg::rsp_t      rsp
);
	import sfa_pkg::*;

	localparam int HEAP_WORDS = HEAP_BYTES / 8;
	localparam int IW         = $clog2(HEAP_WORDS);
	localparam int CW         = $clog2(NUM_CLASSES);
	localparam int LIM        = (HEAP_BYTES < ADDR_SPAN) ? HEAP_BYTES : ADDR_SPAN;
	localparam int GROW       = (CHUNK_BYTES + 15) & ~15;

	state_t            state_q, state_n;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] heads_q [NUM_CLASSES];
	logic [ADDR_W-1:0] brk_q;
	logic [SZ_W-1:0]   cur_q, end_q;
	logic [CW-1:0]     cls_q;
	logic [WORD_W-1:0] size_q;
	logic              oob_q;
	rsp_t              res_q, rsp_q;
	logic              rsp_valid_q;

	logic              ram_we, ram_rd, ram_wr;
	logic [IW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata, rdat, hsize;
	logic [31:0]       widx;
	logic              wok;
	logic [SZ_W-1:0]   bs, bump_sz, bump_end, cur_nx;
	logic              bump_over, bump_fail, rsp_load;
	logic [ADDR_W-1:0] head;
	logic [CLS_W-1:0]  fcls;

	function automatic logic [31:0] hdr_w(input logic [ADDR_W-1:0] a);
		return {18'd0, a[ADDR_W-1:3]} - 32'd1;
	endfunction

	function automatic logic [31:0] lnk_w(input logic [ADDR_W-1:0] a);
		return {18'd0, a[ADDR_W-1:3]};
	endfunction

	sfa_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rdat      = oob_q ? '0 : ram_rdata;
	assign hsize     = rdat & ~WORD_W'(7);
	assign fcls      = class_of(SZ_W'(hsize), NUM_CLASSES);
	assign bs        = SZ_W'(8) << cls_q;
	assign head      = heads_q[cls_q];
	assign bump_sz   = (bs >= SZ_W'(CHUNK_BYTES)) ? bs : SZ_W'(GROW);
	assign bump_end  = SZ_W'(brk_q) + bump_sz;
	assign bump_over = bump_end > SZ_W'(LIM);
	assign bump_fail = bump_over || (brk_q == '0);
	assign cur_nx    = cur_q + bs;
	assign wok       = widx < 32'(HEAP_WORDS);
	assign ram_addr  = widx[IW-1:0];
	assign ram_we    = ram_wr && wok;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		cmd_pop   = 1'b0;
		ram_rd    = 1'b0;
		ram_wr    = 1'b0;
		widx      = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd_q.is_free) begin
					if (cmd_q.addr[ADDR_W-1:3] == '0) begin
						state_n = S_RESP;
					end else begin
						ram_rd  = 1'b1;
						widx    = hdr_w(cmd_q.addr);
						state_n = S_FREE_HDR;
					end
				end else if (cmd_q.status != ST_OK) begin
					state_n = S_RESP;
				end else if (head != '0) begin
					ram_rd  = 1'b1;
					widx    = hdr_w(head);
					state_n = S_POP_HDR;
				end else if (bump_fail) begin
					state_n = S_RESP;
				end else begin
					ram_wr    = 1'b1;
					widx      = hdr_w(brk_q);
					ram_wdata = WORD_W'(bs) | WORD_W'(1);
					state_n   = (bs >= SZ_W'(CHUNK_BYTES)) ? S_RESP : S_CARVE_A;
				end
			end
			S_FREE_HDR: begin
				ram_wr    = 1'b1;
				widx      = hdr_w(cmd_q.addr);
				ram_wdata = hsize;
				state_n   = S_FREE_LINK;
			end
			S_FREE_LINK: begin
				ram_wr    = 1'b1;
				widx      = lnk_w(cmd_q.addr);
				ram_wdata = WORD_W'(head);
				state_n   = S_RESP;
			end
			S_POP_HDR: begin
				ram_rd  = 1'b1;
				widx    = lnk_w(head);
				state_n = S_POP_LINK;
			end
			S_POP_LINK: begin
				ram_wr    = 1'b1;
				widx      = hdr_w(res_q.result_addr);
				ram_wdata = size_q | WORD_W'(1);
				state_n   = S_RESP;
			end
			S_CARVE_A: begin
				if (cur_nx <= end_q) begin
					ram_wr    = 1'b1;
					widx      = hdr_w(cur_q[ADDR_W-1:0]);
					ram_wdata = WORD_W'(bs);
					state_n   = S_CARVE_B;
				end else begin
					state_n = S_RESP;
				end
			end
			S_CARVE_B: begin
				ram_wr    = 1'b1;
				widx      = lnk_w(cur_q[ADDR_W-1:0]);
				ram_wdata = WORD_W'(head);
				state_n   = S_CARVE_A;
			end
			S_RESP: begin
				if (rsp_load)
					state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// heads, break and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++)
				heads_q[i] <= '0;
			brk_q       <= ADDR_W'(8);
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EXEC && !cmd_q.is_free && cmd_q.status == ST_OK
					&& head == '0 && !bump_over)
				brk_q <= bump_end[ADDR_W-1:0];
			if (state_q == S_FREE_LINK)
				heads_q[cls_q] <= cmd_q.addr;
			if (state_q == S_POP_LINK)
				heads_q[cls_q] <= rdat[ADDR_W-1:0];
			if (state_q == S_CARVE_B)
				heads_q[cls_q] <= cur_q[ADDR_W-1:0];
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_rd)
			oob_q <= !wok;
		if (rsp_load)
			rsp_q <= res_q;
		unique case (state_q)
			S_IDLE: begin
				cmd_q              <= cmd;
				cls_q              <= cmd.cls[CW-1:0];
				res_q.result_addr  <= '0;
				res_q.status       <= cmd.is_free ? ST_OK : cmd.status;
			end
			S_EXEC: begin
				if (!cmd_q.is_free && cmd_q.status == ST_OK) begin
					if (head != '0) begin
						res_q.result_addr <= head;
					end else if (bump_fail) begin
						res_q.status <= ST_EXHAUSTED;
					end else begin
						res_q.result_addr <= brk_q;
						cur_q             <= SZ_W'(brk_q) + bs;
						end_q             <= SZ_W'(brk_q) + SZ_W'(CHUNK_BYTES);
					end
				end
			end
			S_FREE_HDR: cls_q  <= fcls[CW-1:0];
			S_POP_HDR:  size_q <= hsize;
			S_CARVE_B:  cur_q  <= cur_nx;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/segregated_free_list_allocator.sv =====
// Top level of the segregated free list allocator: front classifier, command queue, back end.
// Depends on sfa_pkg, sfa_front, sfa_back.
//
//  channel | dir | handshake        | word
//  req     | in  | req_valid/stall  | req_type, req_size, block_addr
//  rsp     | out | rsp_valid/stall  | result_addr, status
//
// Back end takes one command at a time on the single heap RAM port: a free reads the header,
// rewrites it and writes the link; a list pop reads the header and the link and rewrites
// the header; a large bump writes its header; a rejected request or null free goes straight
// to the response; carving a chunk for class bs writes header and link of each further block.
// Front queue holds two commands; rsp has an output register, stalls freeze the back end.
// Reset empties all lists and sets the break to 8; heap RAM is not cleared.
`default_nettype none
module segregated_free_list_allocator #(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096,
	parameter int NUM_CLASSES = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sfa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sfa_pkg::rsp_t      rsp
);
	import sfa_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	sfa_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	sfa_back #(
		.HEAP_BYTES  (HEAP_BYTES),
		.CHUNK_BYTES (CHUNK_BYTES),
		.NUM_CLASSES (NUM_CLASSES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// ===== rtl/sfa_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
// Depends on sfa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sfa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire sfa_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire sfa_pkg::rsp_t rsp
);
	import sfa_pkg::*;

	`AST_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req))
	`AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`AST_NOW(a_fail_null, rsp_valid && rsp.status != ST_OK, rsp.result_addr == '0)
	`AST_NOW(a_addr_min, rsp_valid && rsp.result_addr != '0, rsp.result_addr >= 17'd8)
	`AST_NOW(a_no_early_rsp, $rose(arst_n), !rsp_valid)
endmodule

bind segregated_free_list_allocator sfa_checker u_chk (.*);
`default_nettype wire
